// ===== rtl/core/trace_header_length_parser_core_defines.svh =====
// ----------------------------------------------------------------------------
// Trace header length parser: assertion macros
// Concurrent check macros, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef TRACE_HEADER_LENGTH_PARSER_CORE_DEFINES_SVH
`define TRACE_HEADER_LENGTH_PARSER_CORE_DEFINES_SVH

`ifndef SYNTH
`define THLP_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("thlp check failed");
`define THLP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("thlp check failed");
`else
`define THLP_ASSERT_SAME(label, clk, rst, ante, cons)
`define THLP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/core/thlp_pkg.sv =====
// ----------------------------------------------------------------------------
// Trace header length parser package
// Shared types, codes and constants.
// ----------------------------------------------------------------------------
package thlp_pkg;

   localparam int QUEUE_DEPTH_DEF = 4;
   localparam logic [8:0] MIN_HEADER = 9'd9;
   localparam logic [8:0] COUNT_MAX  = 9'd511;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_SHORT   = 3'd1,
      ST_BADVER  = 3'd2,
      ST_ZEROOPT = 3'd3,
      ST_BADHEX  = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      PH_FLAGS   = 3'd0,
      PH_TASK    = 3'd1,
      PH_OP      = 3'd2,
      PH_OPTLEN  = 3'd3,
      PH_OPTS    = 3'd4,
      PH_DONE    = 3'd5,
      PH_BADVER  = 3'd6,
      PH_ZEROOPT = 3'd7
   } phase_type;

   // one queued transaction after hex pairing
   typedef struct packed {
      logic       has_byte;
      logic [7:0] data;
      logic       last;
      logic       nib_pend;
      logic       hex_err;
   } elem_type;

   function automatic logic [4:0] task_len(input logic [1:0] code);
      logic [4:0] len;
      unique case (code)
         2'd0: len = 5'd4;
         2'd1: len = 5'd8;
         2'd2: len = 5'd12;
         default: len = 5'd20;
      endcase
      return len;
   endfunction

   function automatic logic [3:0] op_len(input logic long_op);
      return long_op ? 4'd8 : 4'd4;
   endfunction

endpackage

// ===== rtl/core/thlp_front.sv =====
// ----------------------------------------------------------------------------
// Trace header length parser front end
// Accepts elements, passes raw bytes or pairs hex characters into bytes, tracks hex errors.
// ----------------------------------------------------------------------------
module thlp_front
   import thlp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic       csr_write_data,
   input  logic       req_valid,
   input  logic       req_data_byte_ok,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_element,
   output logic       push,
   output elem_type   push_elem
);

   logic       mode_ff, mode_in;
   logic [3:0] hi_ff, hi_in;
   logic       pend_ff, pend_in;
   logic       err_ff, err_in;

   logic       hex_ok;
   logic [3:0] hex_val;
   logic [3:0] hi_nx;
   logic       pend_nx, err_nx;

   assign push = req_valid & req_data_byte_ok;

   always_comb begin
      hex_ok  = 1'b1;
      hex_val = 4'd0;
      if (req_data_byte >= 8'h30 && req_data_byte <= 8'h39) begin
         hex_val = 4'(req_data_byte - 8'h30);
      end else if (req_data_byte >= 8'h41 && req_data_byte <= 8'h46) begin
         hex_val = 4'(req_data_byte - 8'h37);
      end else if (req_data_byte >= 8'h61 && req_data_byte <= 8'h66) begin
         hex_val = 4'(req_data_byte - 8'h57);
      end else begin
         hex_ok = 1'b0;
      end
   end

   always_comb begin
      push_elem.last = req_last_element;
      hi_nx          = hi_ff;
      pend_nx        = pend_ff;
      err_nx         = err_ff;
      if (mode_ff) begin
         err_nx = err_ff | ~hex_ok;
         if (pend_ff) begin
            push_elem.has_byte = 1'b1;
            push_elem.data     = {hi_ff, hex_val};
            pend_nx            = 1'b0;
         end else begin
            push_elem.has_byte = 1'b0;
            push_elem.data     = 8'd0;
            hi_nx              = hex_val;
            pend_nx            = 1'b1;
         end
      end else begin
         push_elem.has_byte = 1'b1;
         push_elem.data     = req_data_byte;
      end
      push_elem.nib_pend = pend_nx;
      push_elem.hex_err  = err_nx;
   end

   always_comb begin
      mode_in = csr_write_enable ? csr_write_data : mode_ff;
      hi_in   = hi_ff;
      pend_in = pend_ff;
      err_in  = err_ff;
      if (push) begin
         if (req_last_element) begin
            hi_in   = 4'd0;
            pend_in = 1'b0;
            err_in  = 1'b0;
         end else begin
            hi_in   = hi_nx;
            pend_in = pend_nx;
            err_in  = err_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
         hi_ff   <= 4'd0;
         pend_ff <= 1'b0;
         err_ff  <= 1'b0;
      end else begin
         mode_ff <= mode_in;
         hi_ff   <= hi_in;
         pend_ff <= pend_in;
         err_ff  <= err_in;
      end
   end

endmodule

// ===== rtl/core/thlp_queue.sv =====
// ----------------------------------------------------------------------------
// Trace header length parser queue
// Small FIFO between front end and parser.
// ----------------------------------------------------------------------------
module thlp_queue
   import thlp_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  elem_type push_elem,
   input  logic     pop,
   output logic     full,
   output logic     not_empty,
   output elem_type head
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   elem_type          slot_ff [DEPTH];
   logic [PW-1:0]     wr_ff, wr_in;
   logic [PW-1:0]     rd_ff, rd_in;
   logic [CW-1:0]     cnt_ff, cnt_in;

   assign full      = (cnt_ff == CW'(DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign head      = slot_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : PW'(wr_ff + 1'b1);
      end
      if (pop) begin
         rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : PW'(rd_ff + 1'b1);
      end
      if (push && !pop) begin
         cnt_in = CW'(cnt_ff + 1'b1);
      end else if (pop && !push) begin
         cnt_in = CW'(cnt_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_elem;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ===== rtl/core/thlp_back.sv =====
// ----------------------------------------------------------------------------
// Trace header length parser back end
// Walks the header byte by byte and registers the result transaction.
// ----------------------------------------------------------------------------
module thlp_back
   import thlp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       not_empty,
   input  elem_type   head,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_status,
   output logic [8:0] rsp_header_length,
   output logic       rsp_version_out,
   output logic [4:0] rsp_task_id_length,
   output logic [3:0] rsp_op_id_length,
   output logic [7:0] rsp_options_length
);

   phase_type  phase_ff, phase_in, phase_nx;
   logic [7:0] seg_ff, seg_in, seg_nx;
   logic [8:0] cnt_ff, cnt_in, cnt_nx;
   logic [7:0] flags_ff, flags_in, flags_nx;
   logic [7:0] optl_ff, optl_in, optl_nx;

   logic       vld_ff, vld_in;
   status_type st_ff, st_in, st_nx;
   logic [8:0] hlen_ff, hlen_in;
   logic       ver_ff, ver_in;
   logic [4:0] tlen_ff, tlen_in;
   logic [3:0] olen_ff, olen_in;
   logic [7:0] oarea_ff, oarea_in;

   logic       take;
   logic [7:0] b;
   logic       fin;
   logic [4:0] tl;
   logic [3:0] ol;

   assign pop  = not_empty & (~head.last | ~vld_ff | ~rsp_stall);
   assign take = pop & head.has_byte;
   assign fin  = pop & head.last;
   assign b    = head.data;

   // next state of the header walk
   always_comb begin
      phase_nx = phase_ff;
      seg_nx   = seg_ff;
      cnt_nx   = cnt_ff;
      flags_nx = flags_ff;
      optl_nx  = optl_ff;
      if (take) begin
         if (cnt_ff != COUNT_MAX) begin
            cnt_nx = 9'(cnt_ff + 1'b1);
         end
         unique case (phase_ff)
            PH_FLAGS: begin
               flags_nx = b;
               if (b[7:4] > 4'd1) begin
                  phase_nx = PH_BADVER;
               end else begin
                  phase_nx = PH_TASK;
                  seg_nx   = 8'(task_len(b[1:0]));
               end
            end
            PH_TASK: begin
               seg_nx = 8'(seg_ff - 1'b1);
               if (seg_ff == 8'd1) begin
                  phase_nx = PH_OP;
                  seg_nx   = 8'(op_len(flags_ff[3]));
               end
            end
            PH_OP: begin
               seg_nx = 8'(seg_ff - 1'b1);
               if (seg_ff == 8'd1) begin
                  phase_nx = flags_ff[2] ? PH_OPTLEN : PH_DONE;
               end
            end
            PH_OPTLEN: begin
               optl_nx = b;
               if (b == 8'd0) begin
                  phase_nx = PH_ZEROOPT;
               end else begin
                  phase_nx = PH_OPTS;
                  seg_nx   = b;
               end
            end
            PH_OPTS: begin
               seg_nx = 8'(seg_ff - 1'b1);
               if (seg_ff == 8'd1) begin
                  phase_nx = PH_DONE;
               end
            end
            PH_DONE, PH_BADVER, PH_ZEROOPT: begin
            end
            default: begin
            end
         endcase
      end
      if (fin) begin
         phase_in = PH_FLAGS;
         seg_in   = 8'd0;
         cnt_in   = 9'd0;
         flags_in = 8'd0;
         optl_in  = 8'd0;
      end else begin
         phase_in = phase_nx;
         seg_in   = seg_nx;
         cnt_in   = cnt_nx;
         flags_in = flags_nx;
         optl_in  = optl_nx;
      end
   end

   // result decode
   always_comb begin
      priority if (head.nib_pend) begin
         st_nx = ST_BADHEX;
      end else if (cnt_nx < MIN_HEADER) begin
         st_nx = ST_SHORT;
      end else if (head.hex_err) begin
         st_nx = ST_BADHEX;
      end else if (phase_nx == PH_BADVER) begin
         st_nx = ST_BADVER;
      end else if (phase_nx == PH_DONE) begin
         st_nx = ST_OK;
      end else if (phase_nx == PH_ZEROOPT) begin
         st_nx = ST_ZEROOPT;
      end else begin
         st_nx = ST_SHORT;
      end
      tl = task_len(flags_nx[1:0]);
      ol = op_len(flags_nx[3]);

      vld_in   = fin ? 1'b1 : (vld_ff & rsp_stall);
      st_in    = st_ff;
      hlen_in  = hlen_ff;
      ver_in   = ver_ff;
      tlen_in  = tlen_ff;
      olen_in  = olen_ff;
      oarea_in = oarea_ff;
      if (fin) begin
         st_in    = st_nx;
         hlen_in  = 9'd0;
         ver_in   = 1'b0;
         tlen_in  = 5'd0;
         olen_in  = 4'd0;
         oarea_in = 8'd0;
         if (st_nx == ST_OK) begin
            tlen_in = tl;
            olen_in = ol;
            ver_in  = flags_nx[3] | flags_nx[4];
            if (flags_nx[2]) begin
               oarea_in = optl_nx;
               hlen_in  = 9'(9'd2 + 9'(tl) + 9'(ol) + 9'(optl_nx));
            end else begin
               hlen_in  = 9'(9'd1 + 9'(tl) + 9'(ol));
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_FLAGS;
         seg_ff   <= 8'd0;
         cnt_ff   <= 9'd0;
         flags_ff <= 8'd0;
         optl_ff  <= 8'd0;
         vld_ff   <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         seg_ff   <= seg_in;
         cnt_ff   <= cnt_in;
         flags_ff <= flags_in;
         optl_ff  <= optl_in;
         vld_ff   <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      st_ff    <= st_in;
      hlen_ff  <= hlen_in;
      ver_ff   <= ver_in;
      tlen_ff  <= tlen_in;
      olen_ff  <= olen_in;
      oarea_ff <= oarea_in;
   end

   assign rsp_valid          = vld_ff;
   assign rsp_status         = st_ff;
   assign rsp_header_length  = hlen_ff;
   assign rsp_version_out    = ver_ff;
   assign rsp_task_id_length = tlen_ff;
   assign rsp_op_id_length   = olen_ff;
   assign rsp_options_length = oarea_ff;

endmodule

// ===== rtl/core/trace_header_length_parser_core.sv =====
// ----------------------------------------------------------------------------
// Trace header length parser core
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   data_byte, last_element
//   rsp      out        rsp_valid/rsp_stall   status, lengths, version
//   csr      in         csr_write_enable      hex_input_mode
//
// One element per cycle sustained while req_stall is low. The front end puts a
// buffer's last element into a queue register, then the parser registers its
// result in the output register that drives rsp_valid. req_stall rises only when
// the queue is full, which happens only while a result is held by rsp_stall. Reset is
// synchronous and leaves the core ready in the next cycle.
// ----------------------------------------------------------------------------
`include "trace_header_length_parser_core_defines.svh"

module trace_header_length_parser_core
   import thlp_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic       csr_write_data,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_element,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_status,
   output logic [8:0] rsp_header_length,
   output logic       rsp_version_out,
   output logic [4:0] rsp_task_id_length,
   output logic [3:0] rsp_op_id_length,
   output logic [7:0] rsp_options_length
);

   logic     push, pop, q_full, q_not_empty;
   elem_type push_elem, head;

   assign req_stall = q_full;

   thlp_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_data_byte_ok (~q_full),
      .req_data_byte    (req_data_byte),
      .req_last_element (req_last_element),
      .push             (push),
      .push_elem        (push_elem)
   );

   thlp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_elem (push_elem),
      .pop       (pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head      (head)
   );

   thlp_back u_back (
      .clock              (clock),
      .reset              (reset),
      .not_empty          (q_not_empty),
      .head               (head),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_header_length  (rsp_header_length),
      .rsp_version_out    (rsp_version_out),
      .rsp_task_id_length (rsp_task_id_length),
      .rsp_op_id_length   (rsp_op_id_length),
      .rsp_options_length (rsp_options_length)
   );

   `THLP_ASSERT_SAME(a_ok_lengths, clock, reset, rsp_valid && rsp_status == ST_OK, rsp_header_length >= 9'd9 && rsp_task_id_length != 5'd0)
   `THLP_ASSERT_SAME(a_err_zero, clock, reset, rsp_valid && rsp_status != ST_OK, rsp_header_length == 9'd0 && rsp_op_id_length == 4'd0)
   `THLP_ASSERT_SAME(a_long_op_ver, clock, reset, rsp_valid && rsp_op_id_length == 4'd8, rsp_version_out)
   `THLP_ASSERT_NEXT(a_stall_full, clock, reset, q_full && !pop, req_stall)

endmodule

// ===== tb/tb_trace_header_length_parser_core.sv =====
// ----------------------------------------------------------------------------
// Testbench: trace header length parser core
// Sends whole buffers, in raw byte mode and in hex character mode, through
// the request channel. A parser model built into the testbench predicts the
// result of every buffer. Each result transaction is checked field by field
// against the oldest prediction. Directed buffers come first: the smallest
// and largest headers, every status, counter saturation and a mode switch
// inside a buffer. Random buffers follow under several idle and stall
// profiles, with a long receiver hold-off and a sender pause.
// ----------------------------------------------------------------------------
module tb_trace_header_length_parser_core;
   import thlp_pkg::*;

   localparam int QUIET_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 8;
   localparam int LONG_HOLD = 300;
   localparam int MAX_REPORTS = 40;
   localparam logic [8:0] TID_BYTES [4] = '{9'd4, 9'd8, 9'd12, 9'd20};

   typedef logic [7:0] octet_q_t [$];

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } buf_elem_t;

   typedef struct packed {
      status_type status;
      logic [8:0] hdr_len;
      logic       version;
      logic [4:0] tid_len;
      logic [3:0] oid_len;
      logic [7:0] opt_len;
   } header_result_t;

   typedef struct {
      phase_type  phase;
      logic [8:0] remain;
      logic [8:0] count;
      logic [7:0] flags;
      logic [7:0] opt_len;
      logic [3:0] hi_nib;
      logic       nib_pend;
      logic       hex_bad;
   } header_state_t;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_write_enable = 1'b0;
   logic       csr_write_data = 1'b0;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_last_element = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [2:0] rsp_status;
   logic [8:0] rsp_header_length;
   logic       rsp_version_out;
   logic [4:0] rsp_task_id_length;
   logic [3:0] rsp_op_id_length;
   logic [7:0] rsp_options_length;

   buf_elem_t      pending_elems [$];
   header_result_t expected_headers [$];
   header_state_t  hdr;
   logic           hex_mode_model = 1'b0;
   int             elems_queued = 0;
   int             fail_count = 0;
   int             quiet_cycles = 0;
   int             send_idle_pct = 0;
   int             rsp_stall_pct = 0;
   logic           sender_hold = 1'b0;
   int             hold_requests = 0;
   int             hold_served = 0;
   int             hold_left = 0;

   trace_header_length_parser_core i_dut (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_last_element   (req_last_element),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_header_length  (rsp_header_length),
      .rsp_version_out    (rsp_version_out),
      .rsp_task_id_length (rsp_task_id_length),
      .rsp_op_id_length   (rsp_op_id_length),
      .rsp_options_length (rsp_options_length)
   );

   always #1 clock = ~clock;

   // ---------------- header parser model ----------------

   function automatic void clear_header_state();
      hdr.phase = PH_FLAGS;
      hdr.remain = '0;
      hdr.count = '0;
      hdr.flags = '0;
      hdr.opt_len = '0;
      hdr.hi_nib = '0;
      hdr.nib_pend = 1'b0;
      hdr.hex_bad = 1'b0;
   endfunction

   function automatic void absorb_byte(input logic [7:0] b);
      if (hdr.count < COUNT_MAX) hdr.count = hdr.count + 9'd1;
      case (hdr.phase)
         PH_FLAGS: begin
            hdr.flags = b;
            if (b[7:4] > 4'd1) begin
               hdr.phase = PH_BADVER;
            end else begin
               hdr.phase = PH_TASK;
               hdr.remain = TID_BYTES[b[1:0]];
            end
         end
         PH_TASK: begin
            hdr.remain = hdr.remain - 9'd1;
            if (hdr.remain == 9'd0) begin
               hdr.phase = PH_OP;
               hdr.remain = hdr.flags[3] ? 9'd8 : 9'd4;
            end
         end
         PH_OP: begin
            hdr.remain = hdr.remain - 9'd1;
            if (hdr.remain == 9'd0) begin
               if (hdr.flags[2]) hdr.phase = PH_OPTLEN;
               else hdr.phase = PH_DONE;
            end
         end
         PH_OPTLEN: begin
            hdr.opt_len = b;
            if (b == 8'd0) begin
               hdr.phase = PH_ZEROOPT;
            end else begin
               hdr.phase = PH_OPTS;
               hdr.remain = {1'b0, b};
            end
         end
         PH_OPTS: begin
            hdr.remain = hdr.remain - 9'd1;
            if (hdr.remain == 9'd0) hdr.phase = PH_DONE;
         end
         default: ;
      endcase
   endfunction

   function automatic void absorb_element(input logic [7:0] d, input logic closes);
      header_result_t r;
      logic [3:0]     nib;
      if (hex_mode_model) begin
         nib = 4'd0;
         if (d >= "0" && d <= "9") nib = d[3:0];
         else if ((d >= "A" && d <= "F") || (d >= "a" && d <= "f")) nib = d[3:0] + 4'd9;
         else hdr.hex_bad = 1'b1;
         if (hdr.nib_pend) begin
            hdr.nib_pend = 1'b0;
            absorb_byte({hdr.hi_nib, nib});
         end else begin
            hdr.hi_nib = nib;
            hdr.nib_pend = 1'b1;
         end
      end else begin
         absorb_byte(d);
      end
      if (!closes) return;

      r.hdr_len = '0;
      r.version = 1'b0;
      r.tid_len = '0;
      r.oid_len = '0;
      r.opt_len = '0;
      if (hdr.nib_pend) r.status = ST_BADHEX;
      else if (hdr.count < MIN_HEADER) r.status = ST_SHORT;
      else if (hdr.hex_bad) r.status = ST_BADHEX;
      else if (hdr.phase == PH_BADVER) r.status = ST_BADVER;
      else if (hdr.phase == PH_DONE) r.status = ST_OK;
      else if (hdr.phase == PH_ZEROOPT) r.status = ST_ZEROOPT;
      else r.status = ST_SHORT;

      if (r.status == ST_OK) begin
         r.tid_len = 5'(TID_BYTES[hdr.flags[1:0]]);
         r.oid_len = hdr.flags[3] ? 4'd8 : 4'd4;
         r.version = hdr.flags[3] | hdr.flags[4];
         r.hdr_len = 9'd1 + TID_BYTES[hdr.flags[1:0]] + {5'd0, r.oid_len};
         if (hdr.flags[2]) begin
            r.opt_len = hdr.opt_len;
            r.hdr_len = r.hdr_len + 9'd1 + {1'b0, hdr.opt_len};
         end
      end
      expected_headers.push_back(r);
      clear_header_state();
   endfunction

   // ---------------- request driver ----------------

   always @(posedge clock) begin : driver
      buf_elem_t nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) absorb_element(req_data_byte, req_last_element);
         if (!req_valid || !req_stall) begin
            if (!sender_hold && pending_elems.size() != 0 &&
                $urandom_range(0, 99) >= send_idle_pct) begin
               nxt = pending_elems.pop_front();
               req_valid <= 1'b1;
               req_data_byte <= nxt.data;
               req_last_element <= nxt.last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------- result monitor ----------------

   function automatic void check_field(input string what, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         if (fail_count < MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin : monitor
      header_result_t want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_headers.size() == 0) begin
               if (fail_count < MAX_REPORTS)
                  $display("%0t: unexpected result transaction, expected none, actual status %0d",
                           $time, rsp_status);
               fail_count++;
            end else begin
               want = expected_headers.pop_front();
               check_field("status", want.status, rsp_status);
               check_field("header_length", want.hdr_len, rsp_header_length);
               check_field("version_out", want.version, rsp_version_out);
               check_field("task_id_length", want.tid_len, rsp_task_id_length);
               check_field("op_id_length", want.oid_len, rsp_op_id_length);
               check_field("options_length", want.opt_len, rsp_options_length);
            end
         end
         if (hold_served != hold_requests) begin
            hold_served++;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
         end
      end
   end

   // ---------------- watchdog ----------------

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(negedge clock);
      $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
      $display("Simulation FAILED");
      $finish;
   end

   // ---------------- buffer builders ----------------

   function automatic void add_random(ref octet_q_t q, input int n);
      for (int i = 0; i < n; i++) q.push_back(8'($urandom_range(0, 255)));
   endfunction

   function automatic octet_q_t fill_octets(input logic [7:0] v, input int n);
      octet_q_t q;
      for (int i = 0; i < n; i++) q.push_back(v);
      return q;
   endfunction

   function automatic octet_q_t header_bytes(input logic [7:0] flags, input logic [7:0] olen,
                                             input int trailing);
      octet_q_t q;
      q.push_back(flags);
      add_random(q, int'(TID_BYTES[flags[1:0]]) + (flags[3] ? 8 : 4));
      if (flags[2]) begin
         q.push_back(olen);
         add_random(q, int'(olen));
      end
      add_random(q, trailing);
      return q;
   endfunction

   function automatic logic [7:0] nibble_char(input logic [3:0] n);
      if (n < 4'd10) return 8'h30 + {4'd0, n};
      if ($urandom_range(0, 1) == 0) return 8'h37 + {4'd0, n};
      return 8'h57 + {4'd0, n};
   endfunction

   function automatic octet_q_t hex_chars(input octet_q_t octets);
      octet_q_t q;
      foreach (octets[i]) begin
         q.push_back(nibble_char(octets[i][7:4]));
         q.push_back(nibble_char(octets[i][3:0]));
      end
      return q;
   endfunction

   function automatic logic [7:0] non_hex_char();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255));
      while ((c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f"));
      return c;
   endfunction

   task automatic queue_elements(input octet_q_t elems, input bit closes);
      buf_elem_t e;
      foreach (elems[i]) begin
         e.data = elems[i];
         e.last = closes && (i == elems.size() - 1);
         pending_elems.push_back(e);
      end
      elems_queued += elems.size();
   endtask

   task automatic send_bytes(input octet_q_t octets, input bit closes);
      if (hex_mode_model) queue_elements(hex_chars(octets), closes);
      else queue_elements(octets, closes);
   endtask

   task automatic random_buffer();
      octet_q_t   q;
      logic [7:0] flags;
      logic [7:0] olen;
      int         pick;
      int         cut;
      pick = $urandom_range(0, 99);
      if (pick < 72) begin
         flags = 8'($urandom_range(0, 255));
         flags[7:4] = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(2, 15))
                                                  : 4'($urandom_range(0, 1));
         cut = $urandom_range(0, 99);
         if (cut < 5) olen = 8'd0;
         else if (cut < 8) olen = 8'($urandom_range(17, 255));
         else olen = 8'($urandom_range(1, 16));
         q = header_bytes(flags, olen, $urandom_range(0, 4));
         if ($urandom_range(0, 9) == 0) begin
            cut = $urandom_range(1, q.size());
            while (q.size() > cut) void'(q.pop_back());
         end
      end else if (pick < 88) begin
         add_random(q, $urandom_range(9, 32));
      end else begin
         add_random(q, $urandom_range(1, 8));
      end
      if (hex_mode_model) begin
         q = hex_chars(q);
         if ($urandom_range(0, 11) == 0) q[$urandom_range(0, q.size() - 1)] = non_hex_char();
         if ($urandom_range(0, 14) == 0) void'(q.pop_back());
      end
      queue_elements(q, 1'b1);
   endtask

   task automatic random_buffers(input int n_elems);
      int target;
      target = elems_queued + n_elems;
      while (elems_queued < target) random_buffer();
   endtask

   task automatic wait_idle();
      while (pending_elems.size() != 0 || req_valid || expected_headers.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_mode(input bit hex);
      wait_idle();
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= hex;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      hex_mode_model = hex;
      @(negedge clock);
   endtask

   // ---------------- sequence ----------------

   initial begin
      octet_q_t octets;
      clear_header_state();
      send_idle_pct = 22;
      rsp_stall_pct = 77;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // raw bytes: smallest and largest headers, every status but bad hex
      send_bytes(header_bytes(8'h00, 8'd0, 0), 1'b1);
      send_bytes(header_bytes(8'h1F, 8'hFF, 0), 1'b1);
      send_bytes(fill_octets(8'hFF, 1), 1'b1);
      send_bytes(fill_octets(8'h00, 8), 1'b1);
      send_bytes(header_bytes(8'hF0, 8'd0, 0), 1'b1);
      send_bytes(header_bytes(8'h20, 8'd0, 2), 1'b1);
      send_bytes(header_bytes(8'h04, 8'd0, 3), 1'b1);
      octets = header_bytes(8'h06, 8'd40, 0);
      while (octets.size() > 20) void'(octets.pop_back());
      send_bytes(octets, 1'b1);
      send_bytes(header_bytes(8'h08, 8'd0, 1), 1'b1);
      send_bytes(header_bytes(8'h11, 8'd0, 0), 1'b1);
      // long buffer, byte count saturates
      send_bytes(header_bytes(8'h17, 8'd7, 500), 1'b1);

      // hex characters
      set_mode(1'b1);
      send_bytes(header_bytes(8'h1D, 8'd3, 2), 1'b1);
      queue_elements(fill_octets("0", 3), 1'b1);
      octets = hex_chars(header_bytes(8'h00, 8'd0, 0));
      octets[5] = 8'hFF;
      queue_elements(octets, 1'b1);
      octets = hex_chars(header_bytes(8'h01, 8'd0, 0));
      octets[12] = "G";
      queue_elements(octets, 1'b1);
      octets.delete();
      octets.push_back(8'h00);
      octets.push_back("0");
      queue_elements(octets, 1'b1);

      // mode switched inside a buffer
      send_bytes(fill_octets(8'h00, 1), 1'b0);
      set_mode(1'b0);
      octets.delete();
      add_random(octets, 8);
      send_bytes(octets, 1'b1);
      octets.delete();
      octets.push_back(8'h00);
      add_random(octets, 2);
      send_bytes(octets, 1'b0);
      set_mode(1'b1);
      octets.delete();
      add_random(octets, 6);
      send_bytes(octets, 1'b1);
      queue_elements(fill_octets("A", 1), 1'b0);
      set_mode(1'b0);
      octets.delete();
      add_random(octets, 9);
      send_bytes(octets, 1'b1);

      set_mode(1'b1);
      random_buffers(120);
      set_mode(1'b0);
      random_buffers(80);

      send_idle_pct = 77;
      rsp_stall_pct = 22;
      set_mode(1'b1);
      random_buffers(100);
      set_mode(1'b0);
      random_buffers(60);

      send_idle_pct = 0;
      rsp_stall_pct = 0;
      // receiver holds off while one-byte buffers back up the core
      wait_idle();
      hold_requests++;
      for (int i = 0; i < 40; i++) send_bytes(fill_octets(8'($urandom_range(0, 255)), 1), 1'b1);
      wait_idle();
      // sender pauses until every result is out
      random_buffers(50);
      while (pending_elems.size() > 25) @(negedge clock);
      sender_hold = 1'b1;
      while (req_valid || expected_headers.size() != 0) @(negedge clock);
      sender_hold = 1'b0;
      set_mode(1'b1);
      random_buffers(60);
      set_mode(1'b0);
      random_buffers(60);

      while (pending_elems.size() != 0 || req_valid || expected_headers.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== trace_header_length_parser_core.f =====
+incdir+rtl/core
rtl/core/thlp_pkg.sv
rtl/core/thlp_front.sv
rtl/core/thlp_queue.sv
rtl/core/thlp_back.sv
rtl/core/trace_header_length_parser_core.sv
tb/tb_trace_header_length_parser_core.sv
